// ===== hdl/ddm_pkg.sv =====
// Shared types and constants for the decimal digit multiplier.
// No dependencies; imported by decimal_digit_multiplier.
`default_nettype none

package ddm_pkg;

  typedef logic [3:0] digit_t;
  typedef logic [6:0] digit_sum_t;

  localparam digit_t DIGIT_MAX = 4'd9;
  localparam logic [6:0] DECIMAL_BASE = 7'd10;

  // Reciprocal of ten scaled by 2^10; exact for every sum up to 99.
  localparam logic [13:0] DIV10_RECIP = 14'd103;
  localparam int DIV10_SHIFT = 10;

  // Quotient of a column sum by ten, without a divider.
  function automatic digit_t dm_div10(input digit_sum_t t);
    logic [13:0] scaled;
    begin
      scaled = 14'(t) * DIV10_RECIP;
      dm_div10 = 4'(scaled >> DIV10_SHIFT);
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/decimal_digit_multiplier.sv =====
// Signed decimal long multiplier over digit streams (top level).
// Depends on ddm_pkg for digit types and the divide-by-ten helper.
`default_nettype none

// Channel  | Direction | Fields                               | Handshake
// in_      | input     | op, digit, negative, last            | in_valid / in_stall
// out_     | output    | minus, digit_res, error, last_res    | out_valid / out_stall
//
// Each operand digit request is taken while the block is idle.
// The B request carrying last starts the product: with n and m significant
// digits the schoolbook pass runs n rows of m digit pairs and a carry step,
// one digit pair per cycle through the product memory's read port and write
// port, then a drain step and a sign step, and a memory read then an output
// register for each product position read back, a zero top position included,
// plus waits on out_stall. An error or a zero product is a single request.
// Reset is synchronous; no memory clearing pass is needed.
// The final result waits in the output register while new operands load.
module decimal_digit_multiplier #(
  parameter int MAX_DIGITS = 31
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_op,
  input  ddm_pkg::digit_t   in_digit,
  input  wire               in_negative,
  input  wire               in_last,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              out_minus,
  output ddm_pkg::digit_t   out_digit_res,
  output logic              out_error,
  output logic              out_last_res
);

  import ddm_pkg::*;

  // Widths: counts hold 0..MAX_DIGITS, operand addresses 0..MAX_DIGITS-1,
  // product addresses 0..2*MAX_DIGITS-1.
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PW = $clog2(2 * MAX_DIGITS);
  localparam int PD = 2 * MAX_DIGITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_WT    = 3'd5;
  localparam logic [2:0] ST_ONE   = 3'd6;

  // Digit stores. Operands are kept most significant digit first; the
  // product is kept units first.
  digit_t a_mem [MAX_DIGITS];
  digit_t b_mem [MAX_DIGITS];
  digit_t p_mem [PD];

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] a_cnt_r, a_cnt_nxt;
  logic [CW-1:0] b_cnt_r, b_cnt_nxt;
  logic          a_sign_r, a_sign_nxt;
  logic          b_sign_r, b_sign_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [PW-1:0] k_r, k_nxt;
  logic          first_r, first_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_minus_r, out_minus_nxt;
  digit_t        out_digit_r, out_digit_nxt;
  logic          out_error_r, out_error_nxt;
  logic          out_last_r, out_last_nxt;

  // Second stage of the multiply pipeline: memory data arrives here.
  logic          s_valid_r;
  logic [PW-1:0] s_waddr_r;
  logic          s_zero_p_r;
  logic          s_zero_b_r;
  logic          s_first_r;
  logic          fwd_r;
  digit_t        fwd_data_r;
  digit_t        carry_r;
  digit_t        a_q_r, b_q_r, p_q_r;

  logic          in_acc;
  logic          out_free;
  digit_t        d_sat;
  logic          a_we, b_we;
  logic [CW-1:0] a_off, b_off;
  logic [AW-1:0] a_rd, b_rd;
  logic [PW-1:0] p_rd;
  logic          at_row_end;

  digit_t        pv, bv, cin, q_dig, r_dig;
  logic [7:0]    prod;
  digit_sum_t    col_sum;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign d_sat    = (in_digit > DIGIT_MAX) ? DIGIT_MAX : in_digit;

  // Read addresses for the digit pair (i, j): A counts rows from its units
  // digit, B counts columns from its units digit.
  assign a_off = a_cnt_r - CW'(1) - CW'(i_r);
  assign b_off = b_cnt_r - CW'(1) - j_r;
  assign a_rd  = a_off[AW-1:0];
  assign b_rd  = b_off[AW-1:0];
  assign p_rd  = (state_r == ST_MUL) ? (PW'(i_r) + PW'(j_r)) : k_r;
  assign at_row_end = (j_r == b_cnt_r);

  // Column arithmetic. The extra step at j == m adds only the row carry
  // into a position no earlier row has touched, and row 0 starts from zero,
  // so the product store never needs clearing.
  always_comb begin
    pv      = s_zero_p_r ? '0 : (fwd_r ? fwd_data_r : p_q_r);
    bv      = s_zero_b_r ? '0 : b_q_r;
    cin     = s_first_r ? '0 : carry_r;
    prod    = 8'(a_q_r) * 8'(bv);
    col_sum = 7'(pv) + 7'(prod) + 7'(cin);
    q_dig   = dm_div10(col_sum);
    r_dig   = 4'(col_sum - 7'(q_dig) * DECIMAL_BASE);
  end

  always_comb begin
    state_nxt     = state_r;
    a_cnt_nxt     = a_cnt_r;
    b_cnt_nxt     = b_cnt_r;
    a_sign_nxt    = a_sign_r;
    b_sign_nxt    = b_sign_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    first_nxt     = first_r;
    a_we          = 1'b0;
    b_we          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_minus_nxt = out_minus_r;
    out_digit_nxt = out_digit_r;
    out_error_nxt = out_error_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // Leading zeros are dropped; a full store flags overflow instead.
          if (!in_op) begin
            a_sign_nxt = in_negative;
            if (!(a_cnt_r == '0 && d_sat == '0)) begin
              if (a_cnt_r >= CW'(MAX_DIGITS)) begin
                ovf_nxt = 1'b1;
              end else begin
                a_we      = 1'b1;
                a_cnt_nxt = a_cnt_r + CW'(1);
              end
            end
          end else begin
            b_sign_nxt = in_negative;
            if (!(b_cnt_r == '0 && d_sat == '0)) begin
              if (b_cnt_r >= CW'(MAX_DIGITS)) begin
                ovf_nxt = 1'b1;
              end else begin
                b_we      = 1'b1;
                b_cnt_nxt = b_cnt_r + CW'(1);
              end
            end
            if (in_last) begin
              if (ovf_nxt || a_cnt_nxt == '0 || b_cnt_nxt == '0) begin
                state_nxt = ST_ONE;
              end else begin
                state_nxt = ST_MUL;
                i_nxt     = '0;
                j_nxt     = '0;
              end
            end
          end
        end
      end
      ST_MUL: begin
        if (at_row_end) begin
          j_nxt = '0;
          if (CW'(i_r) == a_cnt_r - CW'(1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + AW'(1);
          end
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SIGN;
        k_nxt     = PW'(a_cnt_r) + PW'(b_cnt_r) - PW'(1);
        first_nxt = 1'b1;
      end
      ST_SIGN: begin
        if (a_sign_r == b_sign_r) begin
          state_nxt = ST_RD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_minus_nxt = 1'b1;
          out_digit_nxt = '0;
          out_error_nxt = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_WT;
      end
      ST_WT: begin
        // Only the top position (the final row carry) can be a zero to skip.
        if (first_r && p_q_r == '0) begin
          first_nxt = 1'b0;
          k_nxt     = k_r - PW'(1);
          state_nxt = ST_RD;
        end else if (out_free) begin
          first_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          out_minus_nxt = 1'b0;
          out_digit_nxt = p_q_r;
          out_error_nxt = 1'b0;
          out_last_nxt  = (k_r == '0);
          if (k_r == '0) begin
            state_nxt  = ST_IDLE;
            a_cnt_nxt  = '0;
            b_cnt_nxt  = '0;
            a_sign_nxt = 1'b0;
            b_sign_nxt = 1'b0;
            ovf_nxt    = 1'b0;
          end else begin
            k_nxt     = k_r - PW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      ST_ONE: begin
        // A single request: the error mark, or a plain zero product.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_minus_nxt = 1'b0;
          out_digit_nxt = '0;
          out_error_nxt = ovf_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
          a_cnt_nxt     = '0;
          b_cnt_nxt     = '0;
          a_sign_nxt    = 1'b0;
          b_sign_nxt    = 1'b0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      a_sign_r    <= 1'b0;
      b_sign_r    <= 1'b0;
      ovf_r       <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      s_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_cnt_r     <= a_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      a_sign_r    <= a_sign_nxt;
      b_sign_r    <= b_sign_nxt;
      ovf_r       <= ovf_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      s_valid_r   <= (state_r == ST_MUL);
      // When m is one, a row's carry write lands in the same cycle as the
      // next row's read of that position; the written value is passed on.
      fwd_r       <= s_valid_r && (state_r == ST_MUL) && (s_waddr_r == p_rd);
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    out_minus_r <= out_minus_nxt;
    out_digit_r <= out_digit_nxt;
    out_error_r <= out_error_nxt;
    out_last_r  <= out_last_nxt;
    s_waddr_r   <= p_rd;
    s_zero_p_r  <= (i_r == '0) || at_row_end;
    s_zero_b_r  <= at_row_end;
    s_first_r   <= (j_r == '0);
    fwd_data_r  <= r_dig;
    if (s_valid_r) begin
      carry_r <= q_dig;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_cnt_r[AW-1:0]] <= d_sat;
    end
    a_q_r <= a_mem[a_rd];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_cnt_r[AW-1:0]] <= d_sat;
    end
    b_q_r <= b_mem[b_rd];
  end

  always_ff @(posedge clk) begin
    if (s_valid_r) begin
      p_mem[s_waddr_r] <= r_dig;
    end
    p_q_r <= p_mem[p_rd];
  end

  assign out_valid     = out_valid_r;
  assign out_minus     = out_minus_r;
  assign out_digit_res = out_digit_r;
  assign out_error     = out_error_r;
  assign out_last_res  = out_last_r;

  // The multiply pass only runs on two non-empty operands.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (a_cnt_r != '0 && b_cnt_r != '0))
    else $error("multiply pass started with an empty operand");

  // Column sums stay below one hundred, so every carry is a single digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r |-> (q_dig <= DIGIT_MAX && col_sum < 7'd100))
    else $error("column carry out of range");

  // Operand counts never pass the store depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_cnt_r <= CW'(MAX_DIGITS)) && (b_cnt_r <= CW'(MAX_DIGITS)))
    else $error("operand count beyond store depth");

  // A minus request is never the final request of a product.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_minus_r) |-> (!out_last_r && !out_error_r))
    else $error("minus request marked final or erroneous");

endmodule

`default_nettype wire

// ===== test/tb_decimal_digit_multiplier.sv =====
// Self-checking testbench for decimal_digit_multiplier: digit requests in, product digits out.
// Depends on ddm_pkg for the digit type and the saturation limit, and on the RTL top level.

module tb_decimal_digit_multiplier;
  timeunit 1ns;
  timeprecision 1ps;

  // The digit capacity of each operand; a product has at most twice as many digits.
  localparam int OPERAND_DIGITS = 31;
  localparam int PRODUCT_DIGITS = 2 * OPERAND_DIGITS;

  // A 31 by 31 digit product goes through the schoolbook pass with no handshake on
  // either channel, and the long hold-off of the receiver moves nothing either.
  // The watchdog allows several times the longer of the two.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  // After the last product digit has come, watch for strays a little longer.
  localparam int TAIL_CYCLES = 100;
  localparam int REPORT_CAP = 40;

  // Operand selection on the op field.
  localparam logic OPERAND_A = 1'b0;
  localparam logic OPERAND_B = 1'b1;

  // One input request, as it travels on the in_ ports.
  typedef struct packed {
    logic            op;
    ddm_pkg::digit_t digit;
    logic            negative;
    logic            last;
  } digit_req_t;

  // One output item: a minus sign, a product digit or an error mark.
  typedef struct packed {
    logic            minus;
    ddm_pkg::digit_t digit;
    logic            error;
    logic            last;
  } product_item_t;

  typedef digit_req_t request_list_t[$];

  // Every input of the block starts at a known value.
  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_op = 1'b0;
  ddm_pkg::digit_t in_digit = '0;
  logic            in_negative = 1'b0;
  logic            in_last = 1'b0;
  logic            out_stall = 1'b0;
  logic            in_stall;
  logic            out_valid;
  logic            out_minus;
  ddm_pkg::digit_t out_digit_res;
  logic            out_error;
  logic            out_last_res;

  // Idling percentages of the current phase, and the length of a requested hold-off.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_off_cycles = 0;

  int unsigned requests_sent = 0;
  int unsigned mismatch_count = 0;

  // The predictor's own copy of the operand state.
  ddm_pkg::digit_t a_digits [OPERAND_DIGITS];
  ddm_pkg::digit_t b_digits [OPERAND_DIGITS];
  int unsigned     a_len = 0;
  int unsigned     b_len = 0;
  logic            a_neg = 1'b0;
  logic            b_neg = 1'b0;
  logic            digits_overflowed = 1'b0;

  // Product items that the block still owes us, oldest first.
  product_item_t product_items_due [$];

  decimal_digit_multiplier #(
    .MAX_DIGITS(OPERAND_DIGITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_digit(in_digit),
    .in_negative(in_negative),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_minus(out_minus),
    .out_digit_res(out_digit_res),
    .out_error(out_error),
    .out_last_res(out_last_res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Prints one line per mismatch, up to a cap so a broken block cannot flood the log,
  // but every mismatch is counted.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // Works out the product of the two stored operands by long multiplication, one
  // digit of A against every digit of B per row, with decimal carries. The column
  // array holds the product with the units in entry zero. Then queues the items the
  // block should emit and clears the operands for the next pair.
  function automatic void multiply_operands();
    int unsigned column [PRODUCT_DIGITS];
    int unsigned i, j, k, carry, partial, top;
    if (digits_overflowed) begin
      product_items_due.push_back(product_item_t'{1'b0, 4'd0, 1'b1, 1'b1});
    end else begin
      for (k = 0; k < PRODUCT_DIGITS; k++) begin
        column[k] = 0;
      end
      for (i = 0; i < a_len; i++) begin
        carry = 0;
        for (j = 0; j < b_len; j++) begin
          partial = column[i + j] + a_digits[a_len - 1 - i] * b_digits[b_len - 1 - j] + carry;
          column[i + j] = partial % 10;
          carry = partial / 10;
        end
        if (i + b_len < PRODUCT_DIGITS) begin
          column[i + b_len] += carry;
        end
      end
      // The highest non-zero column decides how many digits are sent.
      top = 0;
      for (k = 0; k < a_len + b_len; k++) begin
        if (column[k] != 0) begin
          top = k + 1;
        end
      end
      if (top == 0) begin
        // A zero product is a lone zero digit, never signed.
        product_items_due.push_back(product_item_t'{1'b0, 4'd0, 1'b0, 1'b1});
      end else begin
        if (a_neg != b_neg) begin
          product_items_due.push_back(product_item_t'{1'b1, 4'd0, 1'b0, 1'b0});
        end
        for (k = top; k > 0; k--) begin
          product_items_due.push_back(
            product_item_t'{1'b0, ddm_pkg::digit_t'(column[k - 1]), 1'b0, (k == 1)});
        end
      end
    end
    a_len = 0;
    b_len = 0;
    a_neg = 1'b0;
    b_neg = 1'b0;
    digits_overflowed = 1'b0;
  endfunction

  // Updates the operand state with one accepted request. Digits above nine are
  // saturated, leading zeros are dropped, and the latest request of an operand
  // sets its sign. A significant digit beyond the capacity marks an overflow.
  function automatic void absorb_digit(input digit_req_t req);
    ddm_pkg::digit_t value;
    value = (req.digit > ddm_pkg::DIGIT_MAX) ? ddm_pkg::DIGIT_MAX : req.digit;
    if (req.op == OPERAND_A) begin
      a_neg = req.negative;
      if (a_len != 0 || value != 0) begin
        if (a_len == OPERAND_DIGITS) begin
          digits_overflowed = 1'b1;
        end else begin
          a_digits[a_len] = value;
          a_len++;
        end
      end
    end else begin
      b_neg = req.negative;
      if (b_len != 0 || value != 0) begin
        if (b_len == OPERAND_DIGITS) begin
          digits_overflowed = 1'b1;
        end else begin
          b_digits[b_len] = value;
          b_len++;
        end
      end
      // Only the final request of B starts the multiplication; last on A is ignored.
      if (req.last) begin
        multiply_operands();
      end
    end
  endfunction

  // Offers one request and holds it until the block takes it. Valid stays high after
  // the handshake, so a following call can put up its request at once; the idle gap
  // ahead of a request and the wait for results are the only places that lower it.
  task automatic send_request(input digit_req_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= req.op;
    in_digit    <= req.digit;
    in_negative <= req.negative;
    in_last     <= req.last;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    absorb_digit(req);
    requests_sent++;
  endtask

  // The sender goes quiet until the block has delivered every product digit it owes.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (product_items_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Picks how many significant digits a random operand gets: mostly short, now
  // and then long, and rarely past the capacity.
  function automatic int unsigned random_operand_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 82) begin
      return $urandom_range(0, 5);
    end else if (roll < 97) begin
      return $urandom_range(6, OPERAND_DIGITS);
    end
    return $urandom_range(OPERAND_DIGITS + 1, OPERAND_DIGITS + 2);
  endfunction

  // Builds the requests of one operand: perhaps a few leading zeros, then the
  // significant digits, the first of them non-zero. Some digits exceed nine, some
  // requests carry the opposite sign, and A requests carry random last bits.
  // The final request of B carries last.
  function automatic request_list_t make_operand(input logic op, input int unsigned size);
    request_list_t reqs;
    digit_req_t    req;
    logic          sign;
    int unsigned   lead, k;
    sign = 1'($urandom_range(1));
    lead = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    for (k = 0; k < lead + size; k++) begin
      req.op = op;
      if (k < lead) begin
        req.digit = 4'd0;
      end else if ($urandom_range(9) == 0) begin
        req.digit = ddm_pkg::digit_t'($urandom_range(10, 15));
      end else if (k == lead) begin
        req.digit = ddm_pkg::digit_t'($urandom_range(1, 9));
      end else begin
        req.digit = ddm_pkg::digit_t'($urandom_range(9));
      end
      req.negative = ($urandom_range(9) == 0) ? ~sign : sign;
      req.last = (op == OPERAND_A) ? 1'($urandom_range(1)) : 1'b0;
      reqs.push_back(req);
    end
    if (op == OPERAND_B) begin
      if (reqs.size() == 0) begin
        reqs.push_back(digit_req_t'{OPERAND_B, 4'd0, sign, 1'b0});
      end
      reqs[reqs.size() - 1].last = 1'b1;
    end
    return reqs;
  endfunction

  // Sends one random multiplication. A quarter of them interleave the A and B
  // requests; the final B request always goes last since it starts the product.
  task automatic send_random_product();
    request_list_t a_part, b_part;
    logic          mixed, take_a;
    a_part = make_operand(OPERAND_A, random_operand_size());
    b_part = make_operand(OPERAND_B, random_operand_size());
    mixed = ($urandom_range(3) == 0);
    while (a_part.size() != 0 || b_part.size() != 0) begin
      take_a = (a_part.size() != 0) &&
               (b_part.size() <= 1 || !mixed || $urandom_range(1) == 1);
      if (take_a) begin
        send_request(a_part.pop_front());
      end else begin
        send_request(b_part.pop_front());
      end
    end
  endtask

  // Short hand-picked products: empty operands, signs, leading zeros, digits above
  // nine, the latest sign winning, interleaved operands, a signed zero product and
  // last on an A request.
  task automatic test_special_cases();
    // Nothing times zero: A never arrives, B is a lone zero.
    send_request(digit_req_t'{OPERAND_B, 4'd0, 1'b0, 1'b1});
    // Minus seven times three.
    send_request(digit_req_t'{OPERAND_A, 4'd7, 1'b1, 1'b0});
    send_request(digit_req_t'{OPERAND_B, 4'd3, 1'b0, 1'b1});
    // Leading zeros on both sides; twelve saturates to nine.
    send_request(digit_req_t'{OPERAND_A, 4'd0, 1'b0, 1'b0});
    send_request(digit_req_t'{OPERAND_A, 4'd0, 1'b0, 1'b0});
    send_request(digit_req_t'{OPERAND_A, 4'd5, 1'b0, 1'b0});
    send_request(digit_req_t'{OPERAND_B, 4'd0, 1'b1, 1'b0});
    send_request(digit_req_t'{OPERAND_B, 4'd12, 1'b1, 1'b1});
    // A turns positive on its second request; fifteen saturates to nine.
    send_request(digit_req_t'{OPERAND_A, 4'd2, 1'b1, 1'b0});
    send_request(digit_req_t'{OPERAND_A, 4'd1, 1'b0, 1'b0});
    send_request(digit_req_t'{OPERAND_B, 4'd15, 1'b1, 1'b0});
    send_request(digit_req_t'{OPERAND_B, 4'd4, 1'b1, 1'b1});
    // Interleaved operands, both negative, with last set on an A request.
    send_request(digit_req_t'{OPERAND_A, 4'd3, 1'b1, 1'b0});
    send_request(digit_req_t'{OPERAND_B, 4'd2, 1'b1, 1'b0});
    send_request(digit_req_t'{OPERAND_A, 4'd4, 1'b1, 1'b1});
    send_request(digit_req_t'{OPERAND_B, 4'd1, 1'b1, 1'b1});
    // A negative operand times zero must give an unsigned zero.
    send_request(digit_req_t'{OPERAND_A, 4'd5, 1'b1, 1'b0});
    send_request(digit_req_t'{OPERAND_B, 4'd0, 1'b0, 1'b1});
    // Last on the first A request must not end the operand early.
    send_request(digit_req_t'{OPERAND_A, 4'd8, 1'b0, 1'b1});
    send_request(digit_req_t'{OPERAND_A, 4'd6, 1'b0, 1'b0});
    send_request(digit_req_t'{OPERAND_B, 4'd1, 1'b0, 1'b1});
    wait_for_results();
  endtask

  // The largest product the block can form, a negative 31 nines times 31 nines,
  // which gives a minus item and 62 digits. Then A gets one significant digit too
  // many, which must give the single error item.
  task automatic test_capacity_extremes();
    int unsigned k;
    for (k = 0; k < OPERAND_DIGITS; k++) begin
      send_request(digit_req_t'{OPERAND_A, 4'd9, 1'b1, 1'b0});
    end
    for (k = 0; k < OPERAND_DIGITS; k++) begin
      send_request(digit_req_t'{OPERAND_B, 4'd9, 1'b0, (k == OPERAND_DIGITS - 1)});
    end
    for (k = 0; k <= OPERAND_DIGITS; k++) begin
      send_request(digit_req_t'{OPERAND_A, ddm_pkg::digit_t'($urandom_range(1, 9)),
                                1'b0, 1'b0});
    end
    send_request(digit_req_t'{OPERAND_B, 4'd5, 1'b1, 1'b1});
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // products, so the block fills up and has to stall its input. Afterwards the
  // sender pauses until every product digit is in.
  task automatic test_output_hold_off();
    hold_off_cycles = HOLD_OFF_CYCLES;
    repeat (3) begin
      send_random_product();
    end
    wait_for_results();
  endtask

  // Random products until the number of requests reaches the target, under one
  // idling pattern for the sender and the receiver.
  task automatic test_random_traffic(input int unsigned target, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned first;
    first = requests_sent;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    while (requests_sent - first < target) begin
      send_random_product();
    end
    wait_for_results();
  endtask

  // The receiver: a requested hold-off is counted down here, otherwise it stalls
  // at random according to the current phase.
  always @(posedge clk) begin
    if (hold_off_cycles != 0) begin
      out_stall <= 1'b1;
      hold_off_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Every accepted result is matched against the oldest item still owed.
  always @(posedge clk) begin : result_check
    product_item_t owed;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (product_items_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result minus=%0b digit=%0d error=%0b last=%0b",
                                  out_minus, out_digit_res, out_error, out_last_res));
      end else begin
        owed = product_items_due.pop_front();
        if (out_minus !== owed.minus || out_digit_res !== owed.digit ||
            out_error !== owed.error || out_last_res !== owed.last) begin
          report_mismatch($sformatf(
            "got minus=%0b digit=%0d error=%0b last=%0b, wanted %0b/%0d/%0b/%0b",
            out_minus, out_digit_res, out_error, out_last_res,
            owed.minus, owed.digit, owed.error, owed.last));
        end
      end
    end
  end

  // Ends the run if no request moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no request accepted for %0d cycles", QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_capacity_extremes();
    test_output_hold_off();
    test_random_traffic(6, 0, 0);
    test_random_traffic(6, 61, 0);
    test_random_traffic(6, 0, 61);
    test_random_traffic(6, 29, 29);

    // Give the block a while to show any result it should not have.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (product_items_due.size() != 0) begin
      report_mismatch($sformatf("%0d product items never arrived", product_items_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
